// ===== rtl/rms_edf_tick_scheduler_macros.svh =====
// assertion macros for the tick scheduler
// used by the top level only, needs clk and rst_n in scope
`ifndef RMS_EDF_TICK_SCHEDULER_MACROS_SVH
`define RMS_EDF_TICK_SCHEDULER_MACROS_SVH

// condition implies consequence in the same cycle
`define RMSEDF_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("scheduler check failed");

// condition implies consequence in the next cycle
`define RMSEDF_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== rtl/rmsedf_pkg.sv =====
// shared types and constants of the tick scheduler
// no dependencies
package rmsedf_pkg;

    localparam int WORK_W    = 16;
    localparam int ID_W      = 8;
    localparam int WHO_W     = 8;
    localparam int KIND_W    = 2;
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int ENTRY_W   = ID_W + WORK_W;

    localparam logic CMD_RELEASE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDLE      = 2'd0,
        KIND_PERIODIC  = 2'd1,
        KIND_APERIODIC = 2'd2
    } kind_t;

    typedef struct packed {
        logic              rms_found;
        logic [WHO_W-1:0]  rms_idx;
        logic              edf_found;
        logic [WORK_W-1:0] best_dist;
        logic [WHO_W-1:0]  best_idx;
    } chain_t;

    typedef struct packed {
        logic rel;
        logic arb;
        logic upd;
        logic dec_rms;
        logic dec_edf;
    } cell_ctl_t;

    typedef struct packed {
        logic late_r;
        logic late_e;
        logic pre_r;
        logic pre_e;
    } cell_stat_t;

    typedef struct packed {
        logic             nonempty;
        logic [ID_W-1:0]  id;
        logic             done;
    } ap_serve_t;

endpackage

// ===== rtl/rmsedf_ifs.sv =====
// channel interfaces of the tick scheduler: items, results, configuration
// depends on rmsedf_pkg
interface rmsedf_item_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [rmsedf_pkg::ID_W-1:0]       ap_id;
    logic [rmsedf_pkg::WORK_W-1:0]     ap_work;
    modport source (output valid, cmd, ap_id, ap_work, input ready);
    modport sink (input valid, cmd, ap_id, ap_work, output ready);
endinterface

interface rmsedf_result_if #(parameter int N_TASKS = 4);
    logic                              valid;
    logic                              ready;
    logic [rmsedf_pkg::TICK_W-1:0]     tick_index;
    logic [rmsedf_pkg::KIND_W-1:0]     rms_kind;
    logic [rmsedf_pkg::WHO_W-1:0]      rms_who;
    logic                              rms_ap_done;
    logic [rmsedf_pkg::KIND_W-1:0]     edf_kind;
    logic [rmsedf_pkg::WHO_W-1:0]      edf_who;
    logic                              edf_ap_done;
    logic [N_TASKS-1:0]                rms_miss;
    logic [N_TASKS-1:0]                edf_miss;
    logic [N_TASKS-1:0]                rms_preempted;
    logic [N_TASKS-1:0]                edf_preempted;
    logic                              ap_overflow;
    modport source (output valid, tick_index, rms_kind, rms_who, rms_ap_done, edf_kind,
                    edf_who, edf_ap_done, rms_miss, edf_miss, rms_preempted, edf_preempted,
                    ap_overflow, input ready);
    modport sink (input valid, tick_index, rms_kind, rms_who, rms_ap_done, edf_kind,
                  edf_who, edf_ap_done, rms_miss, edf_miss, rms_preempted, edf_preempted,
                  ap_overflow, output ready);
endinterface

interface rmsedf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rmsedf_pkg::CFG_IDX_W-1:0]  index;
    logic [rmsedf_pkg::WORK_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rmsedf_cell.sv =====
// one task slot of the scheduler chain: period, work, phase and both pending counters
// depends on rmsedf_pkg
module rmsedf_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          per_we,
    input  logic                          work_we,
    input  logic [rmsedf_pkg::WORK_W-1:0] cfg_data,
    input  rmsedf_pkg::cell_ctl_t         ctl,
    input  rmsedf_pkg::chain_t            chain_in,
    output rmsedf_pkg::chain_t            chain_out,
    output rmsedf_pkg::cell_stat_t        stat
);
    localparam logic [rmsedf_pkg::WHO_W-1:0] MY_IDX = rmsedf_pkg::WHO_W'(IDX);

    logic [rmsedf_pkg::WORK_W-1:0] per_reg, work_reg, phase_reg, rpend_reg, epend_reg;
    logic                          late_r_reg, late_e_reg, pre_r_reg;
    logic [rmsedf_pkg::WORK_W:0]   rsum, esum, phase_inc;
    logic [rmsedf_pkg::WORK_W-1:0] rsat, esat, deadline_gap, epend_after;
    logic                          used, rel_due, r_act, e_act, e_take;

    assign used    = per_reg != '0;
    assign rel_due = used && phase_reg == '0;
    assign rsum    = {1'b0, rpend_reg} + {1'b0, work_reg};
    assign esum    = {1'b0, epend_reg} + {1'b0, work_reg};
    assign rsat    = rsum[rmsedf_pkg::WORK_W] ? '1 : rsum[rmsedf_pkg::WORK_W-1:0];
    assign esat    = esum[rmsedf_pkg::WORK_W] ? '1 : esum[rmsedf_pkg::WORK_W-1:0];
    assign r_act   = used && rpend_reg != '0;
    assign e_act   = used && epend_reg != '0;
    assign deadline_gap = per_reg - phase_reg;
    assign e_take  = e_act && (!chain_in.edf_found || deadline_gap < chain_in.best_dist);
    assign phase_inc   = {1'b0, phase_reg} + 1'b1;
    assign epend_after = epend_reg - {{(rmsedf_pkg::WORK_W-1){1'b0}}, ctl.dec_edf};

    always_comb
    begin
        chain_out           = chain_in;
        chain_out.rms_found = chain_in.rms_found | r_act;
        if (!chain_in.rms_found && r_act)
        begin
            chain_out.rms_idx = MY_IDX;
        end
        if (e_take)
        begin
            chain_out.edf_found = 1'b1;
            chain_out.best_dist = deadline_gap;
            chain_out.best_idx  = MY_IDX;
        end
    end

    assign stat.late_r = late_r_reg;
    assign stat.late_e = late_e_reg;
    assign stat.pre_r  = pre_r_reg;
    assign stat.pre_e  = epend_after != '0 && !ctl.dec_edf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_reg    <= '0;
            work_reg   <= '0;
            phase_reg  <= '0;
            rpend_reg  <= '0;
            epend_reg  <= '0;
            late_r_reg <= 1'b0;
            late_e_reg <= 1'b0;
            pre_r_reg  <= 1'b0;
        end
        else
        begin
            if (per_we)
            begin
                per_reg   <= cfg_data;
                phase_reg <= '0;
            end
            if (work_we)
            begin
                work_reg <= cfg_data;
            end
            if (ctl.rel)
            begin
                late_r_reg <= rel_due && rpend_reg != '0;
                late_e_reg <= rel_due && epend_reg != '0;
                if (rel_due)
                begin
                    rpend_reg <= rsat;
                    epend_reg <= esat;
                end
            end
            if (ctl.arb)
            begin
                pre_r_reg <= r_act && chain_in.rms_found;
            end
            if (ctl.upd)
            begin
                rpend_reg <= rpend_reg - {{(rmsedf_pkg::WORK_W-1){1'b0}}, ctl.dec_rms};
                epend_reg <= epend_after;
                if (used)
                begin
                    phase_reg <= (phase_inc >= {1'b0, per_reg}) ? '0
                                 : phase_inc[rmsedf_pkg::WORK_W-1:0];
                end
            end
        end
    end
endmodule

// ===== rtl/rmsedf_apq.sv =====
// aperiodic job queue: circular buffer with push, head read and in-place head serve
// depends on rmsedf_pkg
module rmsedf_apq #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [rmsedf_pkg::ID_W-1:0]   push_id,
    input  logic [rmsedf_pkg::WORK_W-1:0] push_work,
    input  logic                          rd,
    input  logic                          serve,
    output logic                          drop,
    output rmsedf_pkg::ap_serve_t         head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    logic [rmsedf_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [rmsedf_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]                  head_reg;
    logic [AW:0]                    count_reg, tail_sum, head_inc;
    logic [AW-1:0]                  tail;
    logic [rmsedf_pkg::WORK_W-1:0]  w, wm;
    logic                           full;

    assign full     = count_reg >= DEPTH_W;
    assign drop     = push && full;
    assign tail_sum = {1'b0, head_reg} + count_reg;
    assign tail     = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
    assign head_inc = {1'b0, head_reg} + 1'b1;
    assign w        = rd_data_reg[rmsedf_pkg::WORK_W-1:0];
    assign wm       = (w != '0) ? w - 1'b1 : '0;

    assign head.nonempty = count_reg != '0;
    assign head.id       = rd_data_reg[rmsedf_pkg::ENTRY_W-1:rmsedf_pkg::WORK_W];
    assign head.done     = wm == '0;

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[tail] <= {push_id, push_work};
        end
        else if (serve && wm != '0)
        begin
            mem[head_reg] <= {head.id, wm};
        end
        if (rd)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (push && !full)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (serve && wm == '0)
        begin
            head_reg  <= (head_inc >= DEPTH_W) ? '0 : head_inc[AW-1:0];
            count_reg <= count_reg - 1'b1;
        end
    end
endmodule

// ===== rtl/rms_edf_tick_scheduler.sv =====
// Tick scheduler running rate-monotonic and earliest-deadline-first side by side over
// MAX_TASKS periodic slots held in a chain of slot cells, with one aperiodic queue per
// policy. A release item is taken in the idle state; a tick item steps through
// acceptance, release, arbitration across the slot chain, then update with the result
// load, and no new item is taken until it is back in idle. The update waits while an
// earlier result is still held on the output. Configuration writes are taken in every
// cycle. Depends on rmsedf_pkg, the channel interfaces, rmsedf_cell, rmsedf_apq.
`include "rms_edf_tick_scheduler_macros.svh"

module rms_edf_tick_scheduler #(
    parameter int MAX_TASKS = 4,
    parameter int AP_DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    rmsedf_item_if.sink              item,
    rmsedf_result_if.source          result,
    rmsedf_cfg_if.sink               cfg
);
    typedef enum logic [1:0] {ST_IDLE, ST_REL, ST_ARB, ST_UPD} state_t;

    state_t                          state_reg;
    rmsedf_pkg::chain_t              chain [MAX_TASKS+1];
    rmsedf_pkg::cell_stat_t          stat [MAX_TASKS];
    rmsedf_pkg::ap_serve_t           rq, eq;
    logic [MAX_TASKS-1:0]            dec_rms, dec_edf, late_r, late_e, pre_r, pre_e;
    logic                            rms_found_reg, edf_found_reg, overflow_reg, res_valid_reg;
    logic [rmsedf_pkg::WHO_W-1:0]    rms_idx_reg, edf_idx_reg;
    logic [rmsedf_pkg::TICK_W-1:0]   tick_reg;
    logic                            accept, push, go, upd, serve_r, serve_e, drop_r, drop_e;
    logic [rmsedf_pkg::KIND_W-1:0]   rkind_reg, ekind_reg;
    logic [rmsedf_pkg::WHO_W-1:0]    rwho_reg, ewho_reg;
    logic                            rdone_reg, edone_reg, ovf_out_reg;
    logic [MAX_TASKS-1:0]            late_r_reg, late_e_reg, pre_r_reg, pre_e_reg;
    logic [rmsedf_pkg::TICK_W-1:0]   tick_out_reg;

    assign item.ready = state_reg == ST_IDLE;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign push       = accept && item.cmd == rmsedf_pkg::CMD_RELEASE && item.ap_work != '0;
    assign go         = !res_valid_reg || result.ready;
    assign upd        = state_reg == ST_UPD && go;
    assign serve_r    = upd && !rms_found_reg && rq.nonempty;
    assign serve_e    = upd && !edf_found_reg && eq.nonempty;
    assign chain[0]   = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        rmsedf_pkg::cell_ctl_t ctl;
        assign dec_rms[i] = upd && rms_found_reg && rms_idx_reg == rmsedf_pkg::WHO_W'(i);
        assign dec_edf[i] = upd && edf_found_reg && edf_idx_reg == rmsedf_pkg::WHO_W'(i);
        assign ctl.rel     = state_reg == ST_REL;
        assign ctl.arb     = state_reg == ST_ARB;
        assign ctl.upd     = upd;
        assign ctl.dec_rms = dec_rms[i];
        assign ctl.dec_edf = dec_edf[i];
        assign late_r[i]   = stat[i].late_r;
        assign late_e[i]   = stat[i].late_e;
        assign pre_r[i]    = stat[i].pre_r;
        assign pre_e[i]    = stat[i].pre_e;

        rmsedf_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .per_we    (cfg.valid && cfg.index == rmsedf_pkg::CFG_IDX_W'(i)),
            .work_we   (cfg.valid && cfg.index == rmsedf_pkg::CFG_IDX_W'(MAX_TASKS + i)),
            .cfg_data  (cfg.data),
            .ctl       (ctl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .stat      (stat[i])
        );
    end

    rmsedf_apq #(.DEPTH(AP_DEPTH)) u_rms_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_id   (item.ap_id),
        .push_work (item.ap_work),
        .rd        (state_reg == ST_ARB),
        .serve     (serve_r),
        .drop      (drop_r),
        .head      (rq)
    );

    rmsedf_apq #(.DEPTH(AP_DEPTH)) u_edf_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_id   (item.ap_id),
        .push_work (item.ap_work),
        .rd        (state_reg == ST_ARB),
        .serve     (serve_e),
        .drop      (drop_e),
        .head      (eq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            tick_reg      <= '0;
            rms_found_reg <= 1'b0;
            edf_found_reg <= 1'b0;
            rms_idx_reg   <= '0;
            edf_idx_reg   <= '0;
            rkind_reg     <= rmsedf_pkg::KIND_IDLE;
            ekind_reg     <= rmsedf_pkg::KIND_IDLE;
            rwho_reg      <= '0;
            ewho_reg      <= '0;
            rdone_reg     <= 1'b0;
            edone_reg     <= 1'b0;
            ovf_out_reg   <= 1'b0;
            late_r_reg    <= '0;
            late_e_reg    <= '0;
            pre_r_reg     <= '0;
            pre_e_reg     <= '0;
            tick_out_reg  <= '0;
        end
        else
        begin
            if (drop_r || drop_e)
            begin
                overflow_reg <= 1'b1;
            end
            if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && item.cmd == rmsedf_pkg::CMD_TICK)
                    begin
                        state_reg <= ST_REL;
                    end
                end
                ST_REL:
                begin
                    state_reg <= ST_ARB;
                end
                ST_ARB:
                begin
                    rms_found_reg <= chain[MAX_TASKS].rms_found;
                    rms_idx_reg   <= chain[MAX_TASKS].rms_idx;
                    edf_found_reg <= chain[MAX_TASKS].edf_found;
                    edf_idx_reg   <= chain[MAX_TASKS].best_idx;
                    state_reg     <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (go)
                    begin
                        res_valid_reg <= 1'b1;
                        tick_out_reg  <= tick_reg;
                        tick_reg      <= tick_reg + 1'b1;
                        late_r_reg    <= late_r;
                        late_e_reg    <= late_e;
                        pre_r_reg     <= pre_r;
                        pre_e_reg     <= pre_e;
                        ovf_out_reg   <= overflow_reg;
                        if (rms_found_reg)
                        begin
                            rkind_reg <= rmsedf_pkg::KIND_PERIODIC;
                            rwho_reg  <= rms_idx_reg;
                            rdone_reg <= 1'b0;
                        end
                        else if (rq.nonempty)
                        begin
                            rkind_reg <= rmsedf_pkg::KIND_APERIODIC;
                            rwho_reg  <= rq.id;
                            rdone_reg <= rq.done;
                        end
                        else
                        begin
                            rkind_reg <= rmsedf_pkg::KIND_IDLE;
                            rwho_reg  <= '0;
                            rdone_reg <= 1'b0;
                        end
                        if (edf_found_reg)
                        begin
                            ekind_reg <= rmsedf_pkg::KIND_PERIODIC;
                            ewho_reg  <= edf_idx_reg;
                            edone_reg <= 1'b0;
                        end
                        else if (eq.nonempty)
                        begin
                            ekind_reg <= rmsedf_pkg::KIND_APERIODIC;
                            ewho_reg  <= eq.id;
                            edone_reg <= eq.done;
                        end
                        else
                        begin
                            ekind_reg <= rmsedf_pkg::KIND_IDLE;
                            ewho_reg  <= '0;
                            edone_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.tick_index    = tick_out_reg;
    assign result.rms_kind      = rkind_reg;
    assign result.rms_who       = rwho_reg;
    assign result.rms_ap_done   = rdone_reg;
    assign result.edf_kind      = ekind_reg;
    assign result.edf_who       = ewho_reg;
    assign result.edf_ap_done   = edone_reg;
    assign result.rms_miss      = late_r_reg;
    assign result.edf_miss      = late_e_reg;
    assign result.rms_preempted = pre_r_reg;
    assign result.edf_preempted = pre_e_reg;
    assign result.ap_overflow   = ovf_out_reg;

    `RMSEDF_ASSERT_NEXT(a_upd_loads_result, upd, res_valid_reg)
    `RMSEDF_ASSERT_NOW(a_one_rms_dec, 1'b1, $onehot0(dec_rms))
    `RMSEDF_ASSERT_NOW(a_one_edf_dec, 1'b1, $onehot0(dec_edf))
    `RMSEDF_ASSERT_NEXT(a_tick_starts, accept && item.cmd == rmsedf_pkg::CMD_TICK,
                        state_reg == ST_REL)
endmodule

// ===== bench/tb_rms_edf_tick_scheduler.sv =====
// testbench for the rate-monotonic / earliest-deadline tick scheduler: random and directed
// ticks and releases checked against an in-bench scheduler predictor
// depends on rmsedf_pkg, rmsedf_ifs and rms_edf_tick_scheduler
module tb_rms_edf_tick_scheduler;
    localparam int NT = 4;
    localparam int QD = 16;
    localparam int WATCHDOG = 20000;
    localparam int ID_W = rmsedf_pkg::ID_W;
    localparam int WORK_W = rmsedf_pkg::WORK_W;
    localparam int WHO_W = rmsedf_pkg::WHO_W;
    localparam int TICK_W = rmsedf_pkg::TICK_W;
    localparam int ENTRY_W = rmsedf_pkg::ENTRY_W;
    localparam int CFG_IDX_W = rmsedf_pkg::CFG_IDX_W;

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   ap_id;
        logic [WORK_W-1:0] ap_work;
    } sched_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_index;
        rmsedf_pkg::kind_t  rms_kind;
        logic [WHO_W-1:0]   rms_who;
        logic               rms_ap_done;
        rmsedf_pkg::kind_t  edf_kind;
        logic [WHO_W-1:0]   edf_who;
        logic               edf_ap_done;
        logic [NT-1:0]      rms_miss;
        logic [NT-1:0]      edf_miss;
        logic [NT-1:0]      rms_preempted;
        logic [NT-1:0]      edf_preempted;
        logic               ap_overflow;
    } tick_report_t;

    typedef struct {
        logic [ENTRY_W-1:0] entry [QD];
        int                 head;
        int                 count;
    } job_fifo_t;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORK_A   = 8'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rmsedf_item_if item ();
    rmsedf_result_if #(.N_TASKS(NT)) result ();
    rmsedf_cfg_if cfg ();

    rms_edf_tick_scheduler #(.MAX_TASKS(NT), .AP_DEPTH(QD)) dut (
        .clk(clk), .rst_n(rst_n), .item(item.sink), .result(result.source), .cfg(cfg.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [WORK_W-1:0] period_m [NT];
    logic [WORK_W-1:0] work_m [NT];
    logic [WORK_W-1:0] phase_m [NT];
    logic [WORK_W-1:0] rms_left [NT];
    logic [WORK_W-1:0] edf_left [NT];
    logic [TICK_W-1:0] tick_m;
    logic              overflow_m;
    job_fifo_t         rms_jobs, edf_jobs;

    sched_item_t  pending_items [$];
    tick_report_t expected_ticks [$];
    int  errors = 0;
    int  ticks_seen = 0;
    int  items_sent = 0;
    bit  src_calm = 1'b0, snk_calm = 1'b0;
    bit  stim_done = 1'b0;
    int  idle_cycles = 0;

    function automatic logic [WORK_W-1:0] sat_sum(logic [WORK_W-1:0] a, logic [WORK_W-1:0] b);
        logic [WORK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORK_W] ? '1 : s[WORK_W-1:0];
    endfunction

    function automatic void job_push(ref job_fifo_t q, input logic [ENTRY_W-1:0] e);
        if (q.count >= QD)
        begin
            overflow_m = 1'b1;
            return;
        end
        q.entry[(q.head + q.count) % QD] = e;
        q.count++;
    endfunction

    function automatic logic [ID_W-1:0] job_serve(ref job_fifo_t q, output logic done);
        logic [ID_W-1:0]   id;
        logic [WORK_W-1:0] w;
        id = q.entry[q.head][ENTRY_W-1:WORK_W];
        w = q.entry[q.head][WORK_W-1:0];
        if (w != 0)
            w--;
        done = (w == 0);
        if (done)
        begin
            q.head = (q.head + 1) % QD;
            q.count--;
        end
        else
            q.entry[q.head] = {id, w};
        return id;
    endfunction

    function automatic void sched_reset();
        for (int j = 0; j < NT; j++)
        begin
            period_m[j] = '0; work_m[j] = '0; phase_m[j] = '0;
            rms_left[j] = '0; edf_left[j] = '0;
        end
        rms_jobs.head = 0; rms_jobs.count = 0;
        edf_jobs.head = 0; edf_jobs.count = 0;
        tick_m = '0;
        overflow_m = 1'b0;
    endfunction

    function automatic void sched_write(logic [CFG_IDX_W-1:0] idx, logic [WORK_W-1:0] val);
        if (idx < REG_WORK_A)
        begin
            period_m[idx] = val;
            phase_m[idx] = '0;
        end
        else if (idx < REG_WORK_A + NT)
            work_m[idx - REG_WORK_A] = val;
    endfunction

    function automatic void sched_step(sched_item_t it);
        tick_report_t r;
        int rsel, esel;
        logic [WORK_W-1:0] best, gap;
        logic d;
        if (it.cmd == rmsedf_pkg::CMD_RELEASE)
        begin
            if (it.ap_work != 0)
            begin
                job_push(rms_jobs, {it.ap_id, it.ap_work});
                job_push(edf_jobs, {it.ap_id, it.ap_work});
            end
            return;
        end
        r = '0;
        rsel = -1; esel = -1; best = '0;
        for (int j = 0; j < NT; j++)
        begin
            if (period_m[j] == 0)
                continue;
            if (phase_m[j] == 0)
            begin
                r.rms_miss[j] = (rms_left[j] != 0);
                r.edf_miss[j] = (edf_left[j] != 0);
                rms_left[j] = sat_sum(rms_left[j], work_m[j]);
                edf_left[j] = sat_sum(edf_left[j], work_m[j]);
            end
            if (rms_left[j] != 0)
            begin
                if (rsel < 0)
                    rsel = j;
                else
                    r.rms_preempted[j] = 1'b1;
            end
            gap = period_m[j] - phase_m[j];
            if (edf_left[j] != 0 && (esel < 0 || gap < best))
            begin
                esel = j;
                best = gap;
            end
        end
        r.rms_kind = rmsedf_pkg::KIND_IDLE;
        r.edf_kind = rmsedf_pkg::KIND_IDLE;
        if (rsel >= 0)
        begin
            rms_left[rsel]--;
            r.rms_kind = rmsedf_pkg::KIND_PERIODIC;
            r.rms_who = WHO_W'(rsel);
        end
        else if (rms_jobs.count != 0)
        begin
            r.rms_kind = rmsedf_pkg::KIND_APERIODIC;
            r.rms_who = job_serve(rms_jobs, d);
            r.rms_ap_done = d;
        end
        if (esel >= 0)
        begin
            edf_left[esel]--;
            r.edf_kind = rmsedf_pkg::KIND_PERIODIC;
            r.edf_who = WHO_W'(esel);
        end
        else if (edf_jobs.count != 0)
        begin
            r.edf_kind = rmsedf_pkg::KIND_APERIODIC;
            r.edf_who = job_serve(edf_jobs, d);
            r.edf_ap_done = d;
        end
        for (int j = 0; j < NT; j++)
        begin
            if (j != esel && edf_left[j] != 0)
                r.edf_preempted[j] = 1'b1;
            if (period_m[j] != 0)
                phase_m[j] = (phase_m[j] + 17'd1 >= period_m[j]) ? '0 : phase_m[j] + 1'b1;
        end
        r.tick_index = tick_m;
        r.ap_overflow = overflow_m;
        tick_m++;
        expected_ticks.insert(expected_ticks.size(), r);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.cmd <= rmsedf_pkg::CMD_TICK;
            item.ap_id <= '0;
            item.ap_work <= '0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                sched_step('{item.cmd, item.ap_id, item.ap_work});
                void'(pending_items.pop_front());
            end
            if (!item.valid || item.ready)
            begin
                if (pending_items.size() != 0 && (src_calm || $urandom_range(99) >= 32))
                begin
                    item.valid <= 1'b1;
                    item.cmd <= pending_items[0].cmd;
                    item.ap_id <= pending_items[0].ap_id;
                    item.ap_work <= pending_items[0].ap_work;
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                tick_report_t e;
                ticks_seen++;
                if (expected_ticks.size() == 0)
                begin
                    $error("unexpected result transaction, tick_index %0d", result.tick_index);
                    errors++;
                end
                else
                begin
                    e = expected_ticks.pop_front();
                    if (result.tick_index !== e.tick_index)
                    begin
                        $error("tick_index exp %0d got %0d", e.tick_index, result.tick_index);
                        errors++;
                    end
                    if (result.rms_kind !== e.rms_kind)
                    begin
                        $error("rms_kind exp %0d got %0d", e.rms_kind, result.rms_kind);
                        errors++;
                    end
                    if (result.rms_who !== e.rms_who)
                    begin
                        $error("rms_who exp %0d got %0d", e.rms_who, result.rms_who);
                        errors++;
                    end
                    if (result.rms_ap_done !== e.rms_ap_done)
                    begin
                        $error("rms_ap_done exp %0d got %0d", e.rms_ap_done, result.rms_ap_done);
                        errors++;
                    end
                    if (result.edf_kind !== e.edf_kind)
                    begin
                        $error("edf_kind exp %0d got %0d", e.edf_kind, result.edf_kind);
                        errors++;
                    end
                    if (result.edf_who !== e.edf_who)
                    begin
                        $error("edf_who exp %0d got %0d", e.edf_who, result.edf_who);
                        errors++;
                    end
                    if (result.edf_ap_done !== e.edf_ap_done)
                    begin
                        $error("edf_ap_done exp %0d got %0d", e.edf_ap_done, result.edf_ap_done);
                        errors++;
                    end
                    if (result.rms_miss !== e.rms_miss)
                    begin
                        $error("rms_miss exp %h got %h", e.rms_miss, result.rms_miss);
                        errors++;
                    end
                    if (result.edf_miss !== e.edf_miss)
                    begin
                        $error("edf_miss exp %h got %h", e.edf_miss, result.edf_miss);
                        errors++;
                    end
                    if (result.rms_preempted !== e.rms_preempted)
                    begin
                        $error("rms_preempted exp %h got %h", e.rms_preempted,
                               result.rms_preempted);
                        errors++;
                    end
                    if (result.edf_preempted !== e.edf_preempted)
                    begin
                        $error("edf_preempted exp %h got %h", e.edf_preempted,
                               result.edf_preempted);
                        errors++;
                    end
                    if (result.ap_overflow !== e.ap_overflow)
                    begin
                        $error("ap_overflow exp %0d got %0d", e.ap_overflow, result.ap_overflow);
                        errors++;
                    end
                end
            end
            result.ready <= snk_calm || ($urandom_range(99) >= 32);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // leaves valid high; the caller drops it after its last write
    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [WORK_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        sched_write(idx, val);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_ticks.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic setup_slots(logic [WORK_W-1:0] p [NT], logic [WORK_W-1:0] w [NT]);
        for (int j = 0; j < NT; j++)
        begin
            reg_write(CFG_IDX_W'(REG_PERIOD_A + j), p[j]);
            reg_write(CFG_IDX_W'(REG_WORK_A + j), w[j]);
        end
        cfg.valid <= 1'b0;
    endtask

    function automatic void add_item(sched_item_t it);
        pending_items.insert(pending_items.size(), it);
        items_sent++;
    endfunction

    function automatic void add_tick();
        add_item('{rmsedf_pkg::CMD_TICK, '0, '0});
    endfunction

    function automatic void add_release(logic [ID_W-1:0] id, logic [WORK_W-1:0] w);
        add_item('{rmsedf_pkg::CMD_RELEASE, id, w});
    endfunction

    function automatic void random_item(int tick_pct);
        if ($urandom_range(99) < tick_pct)
            add_item('{rmsedf_pkg::CMD_TICK, ID_W'($urandom), WORK_W'($urandom)});
        else
            add_release(ID_W'($urandom), ($urandom_range(9) == 0) ? WORK_W'($urandom) :
                        WORK_W'($urandom_range(4)));
    endfunction

    initial
    begin
        logic [WORK_W-1:0] p [NT];
        logic [WORK_W-1:0] w [NT];
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        sched_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all slots unused, jobs only, zero-work and full fifo
        src_calm = 1'b1;
        add_tick();
        add_release(8'hFF, 16'd2);
        add_release(8'h00, 16'd0);
        add_release(8'h5A, 16'd1);
        add_tick(); add_tick(); add_tick(); add_tick();
        for (int k = 0; k < 18; k++)
            add_release(ID_W'(k), 16'hFFFF);
        add_tick();
        drain();

        // extremes of periods and work, saturation
        p = '{16'd1, 16'hFFFF, 16'd3, 16'd0};
        w = '{16'hFFFF, 16'd1, 16'd2, 16'hFFFF};
        setup_slots(p, w);
        for (int k = 0; k < 6; k++)
            add_tick();
        drain();
        src_calm = 1'b0;

        // random phases with varying slot settings
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int j = 0; j < NT; j++)
            begin
                p[j] = ($urandom_range(5) == 0) ? 16'd0 : WORK_W'($urandom_range(1, 12));
                w[j] = WORK_W'($urandom_range(0, 3));
            end
            if (ph == 5)
            begin
                p = '{16'd0, 16'd0, 16'd0, 16'd0};
                w = '{16'd0, 16'd0, 16'd0, 16'd0};
            end
            setup_slots(p, w);
            src_calm = (ph == 2);
            snk_calm = (ph == 2);
            for (int k = 0; k < 100; k++)
                random_item(ph == 5 ? 50 : 75);
            drain();
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
        stim_done = 1'b1;
        repeat (20) @(posedge clk);
        $display("ran directed and six random phases: %0d items sent, %0d ticks checked",
                 items_sent, ticks_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
